// File: sv/ictf_pkg.sv
// shared types, constants and tables of the complementary tilt filter
package ictf_pkg;

  localparam int CORDIC_STEPS = 22;
  localparam int SQRT_STEPS   = 32;
  localparam int RECIP_STEPS  = 3;

  // 256000000 = 2^14 * 15625, the 2^14 part is a shift
  // ceil(2^59 / 15625), exact floor quotient for dividends below 2^45
  localparam logic [45:0] RECIP_CONST = 46'd36893488147420;
  localparam logic [59:0] ROUND_HALF  = 60'd128000000;

  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [23:0] GAIN_RESET   = 24'd128070;
  localparam logic [16:0] WEIGHT_RESET = 17'd64225;
  localparam logic signed [25:0] ANGLE_180 = 26'sd11796480;

  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_GYRO_GAIN    = 2'd0;
  localparam cfg_addr_t CFG_BLEND_WEIGHT = 2'd1;

  typedef struct packed {
    logic [19:0]        elapsed_us;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_x;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
  } sample_t;

  typedef struct packed {
    logic valid;
  } queue_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SQRT, ST_CINIT,
    ST_CORDIC, ST_GYRO, ST_BLEND1, ST_BLEND2, ST_PUSH
  } state_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_tab(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/ictf_queue.sv
// two-entry sample queue between the stream input and the filter engine
module ictf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ictf_pkg::sample_t   in_smp,
  output ictf_pkg::sample_t   q_smp,
  output ictf_pkg::queue_ctl_t q_ctl_o,
  input  logic                q_pop
);

  ictf_pkg::sample_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && (cnt_r != 2'd0);
  assign q_smp     = mem_r[rd_ptr_r];
  assign q_ctl_o.valid = (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_smp;
    end
  end

endmodule

// File: sv/ictf_back.sv
// filter engine: squares, sqrt, two cordic lanes, gyro divide and blend
module ictf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  ictf_pkg::cfg_addr_t  cfg_addr,
  input  logic [23:0]          cfg_wdata,
  input  ictf_pkg::sample_t    q_smp,
  input  ictf_pkg::queue_ctl_t q_ctl_i,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata
);

  ictf_pkg::state_t state_r, state_nxt;

  logic [23:0] gain_r;
  logic [16:0] weight_r;

  logic signed [15:0] ax_r, ay_r, az_r;
  logic [16:0] rxm_r, rym_r;
  logic        rxn_r, ryn_r;
  logic [19:0] us_r;

  logic [31:0] sqa_r, sqb_r;
  logic [36:0] px_r, py_r;
  logic [48:0] mxl_r, mxh_r, myl_r, myh_r;

  // gyro quotient by reciprocal multiplication, one per lane
  logic [44:0] nx_r, ny_r;
  logic [45:0] pxll_r, pxlh_r, pxhl_r, pyll_r, pylh_r, pyhl_r;
  logic [44:0] pxhh_r, pyhh_r;
  logic [46:0] sx_r, sy_r;
  logic [31:0] qxm_r, qym_r;
  logic [1:0]  dcnt_r;

  // square root
  logic [63:0] sop_r, sres_r, sone_r;
  logic [4:0]  scnt_r;

  // cordic lanes: roll (r) and pitch (p)
  logic signed [35:0] rx_r, ry_r, px2_r, py2_r;
  logic signed [25:0] rz_r, pz_r;
  logic        rzero_r, pzero_r;
  logic [4:0]  ccnt_r;

  logic signed [31:0] roll_r, pitch_r, gx_r, gy_r;
  logic signed [49:0] wgx_r, wgy_r;
  logic signed [43:0] wax_r, way_r;

  logic [47:0] odata_r;
  logic        ovalid_r;

  // control decode
  logic do_pop, do_load_out, out_free;

  assign out_free   = !ovalid_r || out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign q_pop      = do_pop;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ictf_pkg::ST_IDLE:   if (q_ctl_i.valid) state_nxt = ictf_pkg::ST_MUL1;
      ictf_pkg::ST_MUL1:   state_nxt = ictf_pkg::ST_MUL2;
      ictf_pkg::ST_MUL2:   state_nxt = ictf_pkg::ST_MUL3;
      ictf_pkg::ST_MUL3:   state_nxt = ictf_pkg::ST_SQRT;
      ictf_pkg::ST_SQRT:
        if (scnt_r == 5'(ictf_pkg::SQRT_STEPS - 1)) state_nxt = ictf_pkg::ST_CINIT;
      ictf_pkg::ST_CINIT:  state_nxt = ictf_pkg::ST_CORDIC;
      ictf_pkg::ST_CORDIC:
        if (ccnt_r == 5'(ictf_pkg::CORDIC_STEPS - 1)) state_nxt = ictf_pkg::ST_GYRO;
      ictf_pkg::ST_GYRO:   if (dcnt_r == 2'd0) state_nxt = ictf_pkg::ST_BLEND1;
      ictf_pkg::ST_BLEND1: state_nxt = ictf_pkg::ST_BLEND2;
      ictf_pkg::ST_BLEND2: state_nxt = ictf_pkg::ST_PUSH;
      ictf_pkg::ST_PUSH:   if (out_free) state_nxt = ictf_pkg::ST_IDLE;
      default:             state_nxt = ictf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    do_pop      = 1'b0;
    do_load_out = 1'b0;
    unique case (state_r)
      ictf_pkg::ST_IDLE: do_pop      = q_ctl_i.valid;
      ictf_pkg::ST_PUSH: do_load_out = out_free;
      default: ;
    endcase
  end

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ictf_pkg::ST_IDLE;
      gain_r   <= ictf_pkg::GAIN_RESET;
      weight_r <= ictf_pkg::WEIGHT_RESET;
      roll_r   <= '0;
      pitch_r  <= '0;
      ovalid_r <= 1'b0;
      dcnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_addr == ictf_pkg::CFG_GYRO_GAIN) gain_r <= cfg_wdata;
        else if (cfg_addr == ictf_pkg::CFG_BLEND_WEIGHT) weight_r <= cfg_wdata[16:0];
      end
      if (do_load_out) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      if (state_r == ictf_pkg::ST_MUL3) dcnt_r <= 2'(ictf_pkg::RECIP_STEPS);
      else if (dcnt_r != 2'd0) dcnt_r <= dcnt_r - 2'd1;
      if (state_r == ictf_pkg::ST_BLEND2) begin
        roll_r  <= sat32(35'((wgx_r + 50'(wax_r) + 50'sd32768) >>> 16));
        pitch_r <= sat32(35'((wgy_r + 50'(way_r) + 50'sd32768) >>> 16));
      end
    end
  end

  // datapath
  logic [59:0] mx_sum, my_sum;
  logic [63:0] strial;
  logic signed [35:0] cry, crx, cpy, cpx, rxs, rys, pxs, pys;
  logic signed [34:0] qx, qy;
  logic [16:0] wc;

  always_comb begin
    mx_sum = 60'({mxh_r, 12'd0}) + 60'(mxl_r) + ictf_pkg::ROUND_HALF;
    my_sum = 60'({myh_r, 12'd0}) + 60'(myl_r) + ictf_pkg::ROUND_HALF;
    strial = sres_r + sone_r;
    cry    = 36'(ay_r) <<< 16;
    crx    = 36'(az_r) <<< 16;
    cpy    = -(36'(ax_r) <<< 16);
    cpx    = {4'd0, sres_r[31:0]};
    rxs    = rx_r >>> ccnt_r;
    rys    = ry_r >>> ccnt_r;
    pxs    = px2_r >>> ccnt_r;
    pys    = py2_r >>> ccnt_r;
    qx     = rxn_r ? -$signed({3'b0, qxm_r}) : $signed({3'b0, qxm_r});
    qy     = ryn_r ? -$signed({3'b0, qym_r}) : $signed({3'b0, qym_r});
    wc     = (weight_r > ictf_pkg::WEIGHT_ONE) ? ictf_pkg::WEIGHT_ONE : weight_r;
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      ax_r  <= q_smp.accel_x;
      ay_r  <= q_smp.accel_y;
      az_r  <= q_smp.accel_z;
      rxn_r <= q_smp.rate_x[15];
      ryn_r <= q_smp.rate_y[15];
      rxm_r <= q_smp.rate_x[15] ? 17'(-$signed(17'(q_smp.rate_x))) : 17'(q_smp.rate_x);
      rym_r <= q_smp.rate_y[15] ? 17'(-$signed(17'(q_smp.rate_y))) : 17'(q_smp.rate_y);
      us_r  <= q_smp.elapsed_us;
    end
    if (state_r == ictf_pkg::ST_MUL1) begin
      sqa_r <= 32'(ay_r * ay_r);
      sqb_r <= 32'(az_r * az_r);
      px_r  <= 37'(rxm_r) * 37'(us_r);
      py_r  <= 37'(rym_r) * 37'(us_r);
    end
    if (state_r == ictf_pkg::ST_MUL2) begin
      mxl_r <= 49'(px_r) * 49'(gain_r[11:0]);
      mxh_r <= 49'(px_r) * 49'(gain_r[23:12]);
      myl_r <= 49'(py_r) * 49'(gain_r[11:0]);
      myh_r <= 49'(py_r) * 49'(gain_r[23:12]);
    end
    if (state_r == ictf_pkg::ST_MUL3) begin
      nx_r   <= mx_sum[58:14];
      ny_r   <= my_sum[58:14];
      sop_r  <= {sqa_r + sqb_r, 32'd0};
      sres_r <= '0;
      sone_r <= 64'd1 << 62;
      scnt_r <= '0;
    end
    // quotient = (n * RECIP_CONST) >> 59, split into 23-bit partial products
    if (dcnt_r == 2'd3) begin
      pxll_r <= 46'(nx_r[22:0]) * 46'(ictf_pkg::RECIP_CONST[22:0]);
      pxlh_r <= 46'(nx_r[22:0]) * 46'(ictf_pkg::RECIP_CONST[45:23]);
      pxhl_r <= 46'(nx_r[44:23]) * 46'(ictf_pkg::RECIP_CONST[22:0]);
      pxhh_r <= 45'(nx_r[44:23]) * 45'(ictf_pkg::RECIP_CONST[45:23]);
      pyll_r <= 46'(ny_r[22:0]) * 46'(ictf_pkg::RECIP_CONST[22:0]);
      pylh_r <= 46'(ny_r[22:0]) * 46'(ictf_pkg::RECIP_CONST[45:23]);
      pyhl_r <= 46'(ny_r[44:23]) * 46'(ictf_pkg::RECIP_CONST[22:0]);
      pyhh_r <= 45'(ny_r[44:23]) * 45'(ictf_pkg::RECIP_CONST[45:23]);
    end
    if (dcnt_r == 2'd2) begin
      sx_r <= 47'(pxlh_r) + 47'(pxhl_r) + 47'(pxll_r[45:23]);
      sy_r <= 47'(pylh_r) + 47'(pyhl_r) + 47'(pyll_r[45:23]);
    end
    if (dcnt_r == 2'd1) begin
      qxm_r <= 32'(({pxhh_r, 23'd0} + 68'(sx_r)) >> 36);
      qym_r <= 32'(({pyhh_r, 23'd0} + 68'(sy_r)) >> 36);
    end
    if (state_r == ictf_pkg::ST_SQRT) begin
      if (sop_r >= strial) begin
        sop_r  <= sop_r - strial;
        sres_r <= (sres_r >> 1) + sone_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sone_r <= sone_r >> 2;
      scnt_r <= scnt_r + 5'd1;
    end
    if (state_r == ictf_pkg::ST_CINIT) begin
      ccnt_r  <= '0;
      rzero_r <= (ay_r == 16'sd0) && (az_r == 16'sd0);
      pzero_r <= (ax_r == 16'sd0) && (sres_r[31:0] == 32'd0);
      // negative x: rotate by 180 degrees first
      if (crx < 36'sd0) begin
        rx_r <= -crx;
        ry_r <= -cry;
        rz_r <= (cry >= 36'sd0) ? ictf_pkg::ANGLE_180 : -ictf_pkg::ANGLE_180;
      end else begin
        rx_r <= crx;
        ry_r <= cry;
        rz_r <= '0;
      end
      px2_r <= cpx;
      py2_r <= cpy;
      pz_r  <= '0;
    end
    if (state_r == ictf_pkg::ST_CORDIC) begin
      ccnt_r <= ccnt_r + 5'd1;
      if (ry_r >= 36'sd0) begin
        rx_r <= rx_r + rys;
        ry_r <= ry_r - rxs;
        rz_r <= rz_r + $signed({4'd0, ictf_pkg::atan_tab(ccnt_r)});
      end else begin
        rx_r <= rx_r - rys;
        ry_r <= ry_r + rxs;
        rz_r <= rz_r - $signed({4'd0, ictf_pkg::atan_tab(ccnt_r)});
      end
      if (py2_r >= 36'sd0) begin
        px2_r <= px2_r + pys;
        py2_r <= py2_r - pxs;
        pz_r  <= pz_r + $signed({4'd0, ictf_pkg::atan_tab(ccnt_r)});
      end else begin
        px2_r <= px2_r - pys;
        py2_r <= py2_r + pxs;
        pz_r  <= pz_r - $signed({4'd0, ictf_pkg::atan_tab(ccnt_r)});
      end
    end
    if (state_r == ictf_pkg::ST_GYRO) begin
      gx_r <= sat32(35'(roll_r) + qx);
      gy_r <= sat32(35'(pitch_r) + qy);
    end
    if (state_r == ictf_pkg::ST_BLEND1) begin
      wgx_r <= $signed({1'b0, wc}) * gx_r;
      wgy_r <= $signed({1'b0, wc}) * gy_r;
      wax_r <= $signed({1'b0, 17'(ictf_pkg::WEIGHT_ONE - wc)})
               * (rzero_r ? 26'sd0 : rz_r);
      way_r <= $signed({1'b0, 17'(ictf_pkg::WEIGHT_ONE - wc)})
               * (pzero_r ? 26'sd0 : pz_r);
    end
    if (do_load_out) begin
      odata_r <= {pitch_r[31:8], roll_r[31:8]};
    end
  end

endmodule

// File: sv/imu_complementary_tilt_filter_core.sv
// top level of the complementary roll/pitch tilt filter
// usage:
//   in_* is a stream of raw imu samples, out_* a stream of filtered angles,
//   one output item per input item, in order.
//   a two-entry queue takes input items while the engine works, so in_tready
//   stays high until two samples are waiting behind the one in progress.
//   each sample passes through the engine in order: pop, the multiplies,
//   the bit-serial square root, a pre-rotation, the two cordic lanes, gyro
//   add, the blend and the output load; the gyro quotients come from a
//   reciprocal multiply in the shadow of the square root. the engine takes
//   one sample at a time, and sqrt plus cordic set its pace.
//   the result sits in an output register; while it is not taken and
//   out_tready is low, the engine waits and the queue keeps filling.
//   cfg_we writes gyro_gain (index 0) or blend_weight (index 1); other
//   indexes are ignored. the user must write only while the block is idle;
//   the block itself does not enforce it.
//   reset (rst_n low, synchronous) clears the stored angles to zero, loads
//   the default gain and weight and empties queue and output register.
module imu_complementary_tilt_filter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_us, 4 zero bits
  input  logic [103:0]        in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // roll_out, pitch_out
  output logic [47:0]         out_tdata,
  input  logic                cfg_we,
  input  ictf_pkg::cfg_addr_t cfg_addr,
  input  logic [23:0]         cfg_wdata
);

  ictf_pkg::sample_t    in_smp, q_smp;
  ictf_pkg::queue_ctl_t q_ctl;
  logic                 q_pop;

  assign in_smp = in_tdata[99:0];

  ictf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_smp    (in_smp),
    .q_smp     (q_smp),
    .q_ctl_o   (q_ctl),
    .q_pop     (q_pop)
  );

  ictf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_smp      (q_smp),
    .q_ctl_i    (q_ctl),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: verif/tb.sv
// self-checking testbench of the complementary roll/pitch tilt filter core
module tb;

  localparam int RAND_ITEMS = 1750;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [103:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_we = 1'b0;
  ictf_pkg::cfg_addr_t cfg_addr = ictf_pkg::CFG_GYRO_GAIN;
  logic [23:0] cfg_wdata = '0;

  imu_complementary_tilt_filter_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] roll_q16, pitch_q16;
  logic [23:0] gain_q24;
  logic [16:0] weight_q16;
  logic [47:0] angles_q[$];

  int errors = 0;
  int cycles = 0;
  bit quiet_rx = 0;       // no idling on the receive side
  bit hold_rx = 0;        // long receiver hold-off
  bit quiet_tx = 0;

  function automatic longint fshift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint isqrt(logic [63:0] n);
    logic [63:0] op, res, one;
    op = n; res = 0; one = 64'd1 << 62;
    while (one > op) one >>= 2;
    while (one != 0) begin
      if (op >= res + one) begin
        op = op - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint tilt_atan2(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ictf_pkg::CORDIC_STEPS; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(ictf_pkg::atan_tab(i[4:0]));
      end else begin
        x = x - ys; y = y + xs; z -= longint'(ictf_pkg::atan_tab(i[4:0]));
      end
    end
    return z;
  endfunction

  function automatic longint advance_blend(longint angle, longint rate, longint us,
                                           longint acc);
    logic [63:0] mag;
    longint q, g, w, mix;
    mag = 64'(rate < 0 ? -rate : rate) * 64'(gain_q24) * 64'(us);
    q = longint'((mag + 64'd128000000) / 64'd256000000);
    g = sat32(angle + (rate < 0 ? -q : q));
    w = (weight_q16 > ictf_pkg::WEIGHT_ONE) ? 65536 : longint'(weight_q16);
    mix = w * g + (65536 - w) * acc + 32768;
    return sat32(fshift(mix, 16));
  endfunction

  function automatic logic [47:0] predict_angles(logic [103:0] d);
    longint ax, ay, az, gx, gy, us, r, racc, pacc, rn, pn;
    logic [23:0] ro, po;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    gx = longint'($signed(d[63:48]));
    gy = longint'($signed(d[79:64]));
    us = longint'(d[99:80]);
    r = isqrt(64'(ay * ay + az * az) << 32);
    racc = tilt_atan2(ay * 65536, az * 65536);
    pacc = tilt_atan2(-ax * 65536, r);
    rn = advance_blend(longint'(roll_q16), gx, us, racc);
    pn = advance_blend(longint'(pitch_q16), gy, us, pacc);
    roll_q16 = 32'(rn);
    pitch_q16 = 32'(pn);
    ro = 24'(fshift(rn, 8));
    po = 24'(fshift(pn, 8));
    return {po, ro};
  endfunction

  function automatic logic [103:0] pack_sample(logic [15:0] ax, logic [15:0] ay,
      logic [15:0] az, logic [15:0] gx, logic [15:0] gy, logic [19:0] us);
    return {4'b0, us, gy, gx, az, ay, ax};
  endfunction

  // checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (angles_q.size() == 0) begin
        errors++;
        $display("%0t unexpected item: expected none, actual %h", $time, out_tdata);
      end else begin
        logic [47:0] exp_v;
        exp_v = angles_q.pop_front();
        if (out_tdata[23:0] !== exp_v[23:0]) begin
          errors++;
          $display("%0t roll_out mismatch: expected %h, actual %h", $time,
                   exp_v[23:0], out_tdata[23:0]);
        end
        if (out_tdata[47:24] !== exp_v[47:24]) begin
          errors++;
          $display("%0t pitch_out mismatch: expected %h, actual %h", $time,
                   exp_v[47:24], out_tdata[47:24]);
        end
      end
    end
  end

  // receiver readiness
  always @(posedge clk) begin
    if (hold_rx) out_tready <= 1'b0;
    else if (quiet_rx) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 29);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[imu_complementary_tilt_filter_core] ERROR");
      $finish;
    end
  end

  // in_tvalid stays high after the item until the next idle or drain
  task automatic send_item(logic [103:0] d);
    while (!quiet_tx && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    angles_q.push_back(predict_angles(d));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (angles_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(ictf_pkg::cfg_addr_t a, logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (a == ictf_pkg::CFG_GYRO_GAIN) gain_q24 = v;
    else if (a == ictf_pkg::CFG_BLEND_WEIGHT) weight_q16 = v[16:0];
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] rnd_us();
    case ($urandom_range(5))
      0: return 20'hfffff;
      1: return 20'd0;
      default: return 20'($urandom_range(20000));
    endcase
  endfunction

  typedef struct {
    logic [103:0] sample;
    bit           known;
    logic [47:0]  angles;
  } row_t;

  row_t rows[$];

  initial begin
    logic [103:0] d;
    logic [47:0] tmp;
    roll_q16 = 0; pitch_q16 = 0;
    gain_q24 = ictf_pkg::GAIN_RESET; weight_q16 = ictf_pkg::WEIGHT_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: zero vector and level sample keep angles at zero, plus edge cases
    rows.push_back('{pack_sample(0, 0, 0, 0, 0, 0), 1, 48'h0});
    rows.push_back('{pack_sample(0, 0, 16'd16384, 0, 0, 20'd1000), 1, 48'h0});
    rows.push_back('{pack_sample(0, 0, 16'hc000, 0, 0, 20'd1000), 0, 0}); // -x: 180
    rows.push_back('{pack_sample(0, 16'hffff, 16'h8000, 0, 0, 20'd1), 0, 0});
    rows.push_back('{pack_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                 20'hfffff), 0, 0});
    rows.push_back('{pack_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                 20'hfffff), 0, 0});
    rows.push_back('{pack_sample(16'h7fff, 0, 0, 16'h8000, 16'h7fff, 20'd5000), 0, 0});
    rows.push_back('{pack_sample(16'h8000, 16'h0001, 0, 100, 16'hff9c, 20'd1000), 0, 0});
    rows.push_back('{pack_sample(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                                 20'haaaaa), 0, 0});
    rows.push_back('{pack_sample(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                                 20'h55555), 0, 0});
    foreach (rows[i]) begin
      tmp = predict_angles(rows[i].sample);
      // undo the predictor step of row 0; send_item predicts again
      if (i == 0) begin roll_q16 = 0; pitch_q16 = 0; end
      if (rows[i].known && tmp !== rows[i].angles) begin
        errors++;
        $display("%0t table row %0d: expected %h, actual %h", $time, i,
                 rows[i].angles, tmp);
      end
    end
    roll_q16 = 0; pitch_q16 = 0;
    foreach (rows[i]) send_item(rows[i].sample);
    drain_results();

    // extremes of the registers, plus an ignored index
    write_reg(ictf_pkg::CFG_GYRO_GAIN, 24'hffffff);
    write_reg(ictf_pkg::CFG_BLEND_WEIGHT, 24'h1ffff);        // weight above one
    write_reg(2'd3, 24'h123456);
    for (int i = 0; i < 6; i++)
      send_item(pack_sample(rnd16(), rnd16(), rnd16(), 16'h7fff, 16'h8000, 20'hfffff));
    drain_results();
    write_reg(ictf_pkg::CFG_GYRO_GAIN, 24'd0);
    write_reg(ictf_pkg::CFG_BLEND_WEIGHT, 24'd0);
    for (int i = 0; i < 4; i++)
      send_item(pack_sample(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd_us()));
    drain_results();

    // random phases with changing settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(ictf_pkg::CFG_GYRO_GAIN, ictf_pkg::GAIN_RESET);
                 write_reg(ictf_pkg::CFG_BLEND_WEIGHT, 24'(ictf_pkg::WEIGHT_RESET)); end
        1: begin write_reg(ictf_pkg::CFG_GYRO_GAIN, 24'($urandom));
                 write_reg(ictf_pkg::CFG_BLEND_WEIGHT, 24'd65536); end
        2: write_reg(ictf_pkg::CFG_BLEND_WEIGHT, 24'($urandom_range(65536)));
        3: begin write_reg(ictf_pkg::CFG_GYRO_GAIN, 24'hffffff);
                 write_reg(ictf_pkg::CFG_BLEND_WEIGHT, 24'd65535); end
        default: begin write_reg(ictf_pkg::CFG_GYRO_GAIN, 24'($urandom));
                       write_reg(ictf_pkg::CFG_BLEND_WEIGHT,
                                 24'($urandom_range(70000))); end
      endcase
      quiet_rx = (ph == 2);
      quiet_tx = (ph == 2);
      fork
        if (ph == 1) begin
          // receiver holds off while items keep coming
          hold_rx = 1;
          repeat (600) @(posedge clk);
          hold_rx = 0;
        end
      join_none
      for (int i = 0; i < RAND_ITEMS / 7; i++) begin
        d = pack_sample(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd_us());
        send_item(d);
        if (ph == 4 && i == 100) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (angles_q.size() != 0);
        end
      end
      drain_results();
    end

    if (errors == 0)
      $display("[imu_complementary_tilt_filter_core] OK");
    else
      $display("[imu_complementary_tilt_filter_core] ERROR");
    $finish;
  end

endmodule
